// ===== hw/rtl/page_table_walker_defines.svh =====
// Assertion macros for the page table walker RTL.
`ifndef PAGE_TABLE_WALKER_DEFINES_SVH
`define PAGE_TABLE_WALKER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PTW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page_table_walker: same-cycle check failed");
`define PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page_table_walker: next-cycle check failed");
`else
`define PTW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/ptw_pkg.sv =====
// Types and constants of the page table walker.
package ptw_pkg;

    localparam int VA_W       = 48;
    localparam int ENTRY_W    = 64;
    localparam int RD_ADDR_W  = 36;
    localparam int PA_W       = 52;
    localparam int IDX_W      = 9;
    localparam int CFG_W      = 64;
    localparam int CFG_ADDR_W = 3;
    localparam int ROOT_W     = 36;

    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;

    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_ENTRY     = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_ROOT_TABLE_BASE = 3'd0;

    typedef enum logic [3:0] {
        LVL_PML4 = 4'b0001,
        LVL_PDPT = 4'b0010,
        LVL_PD   = 4'b0100,
        LVL_PT   = 4'b1000
    } t_level;

    typedef struct packed {
        logic             busy;
        t_level           level;
        logic [VA_W-1:0]  va;
    } t_walk_state;

    typedef struct packed {
        logic                 valid;
        logic                 kind;
        logic [RD_ADDR_W-1:0] read_address;
        logic [PA_W-1:0]      phys_addr;
        logic                 fault;
    } t_walk_result;

endpackage

// ===== hw/rtl/ptw_step.sv =====
// One walk step: next walk state and result for a request or returned entry.
module ptw_step #(
    parameter int PHYS_ADDR_BITS = 36
) (
    input  logic [ptw_pkg::ROOT_W-1:0]  i_root_table_base,
    input  logic                        i_operation,
    input  logic [ptw_pkg::VA_W-1:0]    i_virtual_address,
    input  logic [ptw_pkg::ENTRY_W-1:0] i_table_entry,
    input  ptw_pkg::t_walk_state        i_state,
    output ptw_pkg::t_walk_state        o_next_state,
    output ptw_pkg::t_walk_result       o_result
);
    import ptw_pkg::*;

    localparam int PB = PHYS_ADDR_BITS;

    logic [PA_W-1:0]      root_ext;
    logic [PB-1:0]        root_frame;
    logic [PB-1:0]        root_addr;
    logic [PA_W-1:0]      root_addr_ext;
    logic [IDX_W-1:0]     idx_next;
    logic [PB-1:0]        table_addr;
    logic [PA_W-1:0]      table_addr_ext;
    logic [PA_W-1:0]      pa_1g;
    logic [PA_W-1:0]      pa_2m;
    logic [PA_W-1:0]      pa_4k;
    logic                 frame_zero;
    logic [VA_W-1:0]      sva;

    assign sva           = i_state.va;
    assign root_ext      = PA_W'(i_root_table_base);
    assign root_frame    = {root_ext[PB-1:4], 4'b0000};
    assign root_addr     = root_frame + PB'({i_virtual_address[47:39], 3'b000});
    assign root_addr_ext = PA_W'(root_addr);

    always_comb begin
        unique case (i_state.level)
            LVL_PML4: idx_next = sva[38:30];
            LVL_PDPT: idx_next = sva[29:21];
            default:  idx_next = sva[20:12];
        endcase
    end

    assign table_addr     = {i_table_entry[PB-1:12], idx_next, 3'b000};
    assign table_addr_ext = PA_W'(table_addr);
    assign pa_1g          = {i_table_entry[51:30], sva[29:0]};
    assign pa_2m          = PA_W'({i_table_entry[PB-1:21], sva[20:0]});
    assign pa_4k          = PA_W'({i_table_entry[PB-1:12], sva[11:0]});
    assign frame_zero     = (i_table_entry[PB-1:12] == '0);

    always_comb begin
        o_next_state = i_state;
        o_result     = '0;
        if (i_operation == OP_TRANSLATE) begin
            o_next_state.busy     = 1'b1;
            o_next_state.level    = LVL_PML4;
            o_next_state.va       = i_virtual_address;
            o_result.valid        = 1'b1;
            o_result.kind         = KIND_READ;
            o_result.read_address = root_addr_ext[RD_ADDR_W-1:0];
        end else if (i_state.busy) begin
            o_result.valid = 1'b1;
            if (!i_table_entry[PRESENT_BIT]) begin
                o_next_state.busy  = 1'b0;
                o_next_state.level = LVL_PML4;
                o_result.kind      = KIND_DONE;
                o_result.fault     = 1'b1;
            end else begin
                unique case (i_state.level)
                    LVL_PML4: begin
                        o_next_state.level    = LVL_PDPT;
                        o_result.kind         = KIND_READ;
                        o_result.read_address = table_addr_ext[RD_ADDR_W-1:0];
                    end
                    LVL_PDPT: begin
                        if (i_table_entry[LARGE_BIT]) begin
                            o_next_state.busy  = 1'b0;
                            o_next_state.level = LVL_PML4;
                            o_result.kind      = KIND_DONE;
                            o_result.phys_addr = pa_1g;
                        end else begin
                            o_next_state.level    = LVL_PD;
                            o_result.kind         = KIND_READ;
                            o_result.read_address = table_addr_ext[RD_ADDR_W-1:0];
                        end
                    end
                    LVL_PD: begin
                        if (i_table_entry[LARGE_BIT]) begin
                            o_next_state.busy  = 1'b0;
                            o_next_state.level = LVL_PML4;
                            o_result.kind      = KIND_DONE;
                            o_result.phys_addr = pa_2m;
                        end else begin
                            o_next_state.level    = LVL_PT;
                            o_result.kind         = KIND_READ;
                            o_result.read_address = table_addr_ext[RD_ADDR_W-1:0];
                        end
                    end
                    default: begin
                        o_next_state.busy  = 1'b0;
                        o_next_state.level = LVL_PML4;
                        o_result.kind      = KIND_DONE;
                        if (frame_zero) begin
                            o_result.fault = 1'b1;
                        end else begin
                            o_result.phys_addr = pa_4k;
                        end
                    end
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/page_table_walker.sv =====
// Four-level page table walker top level: input stage, step logic, result stage.
// An accepted beat passes the input stage, then the result stage that drives m_tvalid.
// Throughput: one beat per cycle; input stage advances whenever the result stage is free.
// Entry beats while no walk is active give no result beat.
// Reset (synchronous, active low) empties both stages, idles the walk, clears the root base.
`include "page_table_walker_defines.svh"

module page_table_walker #(
    parameter int PHYS_ADDR_BITS = 36
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ptw_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ptw_pkg::CFG_W-1:0]      pwdata,
    output logic [ptw_pkg::CFG_W-1:0]      prdata,
    output logic                           pready,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [111:0]                   s_tdata,  // virtual_address[47:0], table_entry[111:48]
    input  logic [0:0]                     s_tuser,  // operation
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [95:0]                    m_tdata,  // read_address[35:0],
                                                     // phys_addr[87:36], fault[88]
    output logic [0:0]                     m_tuser   // result_kind
);
    import ptw_pkg::*;

    logic                 root_wr;
    logic [ROOT_W-1:0]    r_root;
    logic                 r_in_valid;
    logic                 r_in_op;
    logic [VA_W-1:0]      r_in_va;
    logic [ENTRY_W-1:0]   r_in_entry;
    t_walk_state          r_state;
    t_walk_state          n_state;
    t_walk_result         n_result;
    logic                 r_out_valid;
    logic                 r_out_kind;
    logic [RD_ADDR_W-1:0] r_out_read_address;
    logic [PA_W-1:0]      r_out_phys_addr;
    logic                 r_out_fault;
    logic                 advance;

    assign pready  = 1'b1;
    assign root_wr = psel && penable && pwrite && (paddr == REG_ROOT_TABLE_BASE);
    assign prdata  = (paddr == REG_ROOT_TABLE_BASE) ? CFG_W'(r_root) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else if (root_wr) begin
            r_root <= pwdata[ROOT_W-1:0];
        end
    end

    assign advance  = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_op    <= s_tuser[0];
            r_in_va    <= s_tdata[47:0];
            r_in_entry <= s_tdata[111:48];
        end
    end

    ptw_step #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_step (
        .i_root_table_base (r_root),
        .i_operation       (r_in_op),
        .i_virtual_address (r_in_va),
        .i_table_entry     (r_in_entry),
        .i_state           (r_state),
        .o_next_state      (n_state),
        .o_result          (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{busy: 1'b0, level: LVL_PML4, va: '0};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_tready) begin
            r_out_valid <= advance && n_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && (!r_out_valid || m_tready)) begin
            r_out_kind         <= n_result.kind;
            r_out_read_address <= n_result.read_address;
            r_out_phys_addr    <= n_result.phys_addr;
            r_out_fault        <= n_result.fault;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out_kind;
    assign m_tdata  = {7'b0, r_out_fault, r_out_phys_addr, r_out_read_address};

    `PTW_ASSERT_IMP(a_fault_zero_pa, i_clk, i_rst_n, r_out_valid && r_out_fault,
        (r_out_kind == KIND_DONE) && (r_out_phys_addr == '0))
    `PTW_ASSERT_IMP(a_read_shape, i_clk, i_rst_n, r_out_valid && (r_out_kind == KIND_READ),
        !r_out_fault && (r_out_phys_addr == '0) && (r_out_read_address[2:0] == 3'b000))
    `PTW_ASSERT_NEXT(a_done_idles, i_clk, i_rst_n,
        advance && n_result.valid && (n_result.kind == KIND_DONE),
        !r_state.busy && r_out_valid)

endmodule
